// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the tone generator RTL.
// Each macro takes a label, the clock, the active-low reset, the checked
// expressions and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define STG_ASSERT(label, clk, rstn, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

`define STG_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`define STG_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define STG_ASSERT(label, clk, rstn, expr, msg)

`define STG_ASSERT_IMP(label, clk, rstn, ante, cons, msg)

`define STG_ASSERT_NXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/core/stg_pkg.sv =====
`timescale 1ns / 1ps

package stg_pkg;

  // Field widths.
  localparam int RATE_W   = 17;
  localparam int RAMP_W   = 12;
  localparam int INC_W    = 32;
  localparam int MS_W     = 16;
  localparam int MAG_W    = 15;
  localparam int SAMPLE_W = 16;

  // Serial divider sizing: the dividend covers rate times milliseconds.
  localparam int DIVIDEND_W = RATE_W + MS_W;
  localparam int DIVISOR_W  = RAMP_W;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Frame count scaling. rate*ms/1000 equals (rate*ms/8)/125, and the
  // division by 125 is a multiply by ceil(2^37/125) and a 37-bit shift,
  // which is exact for every dividend below 2^30.
  localparam int SCALED_W     = DIVIDEND_W - 3;
  localparam int RECIP_W      = 31;
  localparam int RECIP_SHIFT  = 37;
  localparam int SCALE_PROD_W = SCALED_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_125 = 31'd1099511628;

  // Constants.
  localparam logic [MAG_W-1:0] FULL_MAG = 15'd22936;

  localparam logic [RATE_W-1:0] RATE_RESET    = 17'd48000;
  localparam logic [RAMP_W-1:0] ATTACK_RESET  = 12'd240;
  localparam logic [RAMP_W-1:0] RELEASE_RESET = 12'd960;

  // Input item kinds.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Register indexes on the configuration port.
  localparam int            REG_IDX_W   = 2;
  localparam logic [REG_IDX_W-1:0] REG_RATE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic                       last;
    logic                       active;
    logic signed [SAMPLE_W-1:0] sample;
  } result_t;

endpackage

// ===== rtl/core/stg_divider.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle.
module stg_divider (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [stg_pkg::DIVIDEND_W-1:0]      dividend,
  input  logic [stg_pkg::DIVISOR_W-1:0]       divisor,
  output logic [stg_pkg::DIVIDEND_W-1:0]      quotient,
  output stg_pkg::div_stat_t                  stat
);

  localparam logic [stg_pkg::DIV_CNT_W-1:0] LAST_STEP =
    stg_pkg::DIV_CNT_W'(stg_pkg::DIVIDEND_W - 1);

  logic [stg_pkg::DIVIDEND_W-1:0] quo_r;
  logic [stg_pkg::DIVISOR_W-1:0]  rem_r;
  logic [stg_pkg::DIVISOR_W-1:0]  den_r;
  logic [stg_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [stg_pkg::DIVISOR_W:0]    rem_sh;
  logic [stg_pkg::DIVISOR_W:0]    rem_sub;
  logic                           fits;

  assign rem_sh  = {rem_r, quo_r[stg_pkg::DIVIDEND_W-1]};
  assign fits    = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[stg_pkg::DIVIDEND_W-2:0], fits};
        rem_r <= fits ? rem_sub[stg_pkg::DIVISOR_W-1:0] : rem_sh[stg_pkg::DIVISOR_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  `STG_ASSERT_NXT(a_start_busy, clk, rst_n, start, busy_r, "divider did not go busy on start")
  `STG_ASSERT_IMP(a_cnt_range, clk, rst_n, busy_r, cnt_r <= LAST_STEP, "divider step count overran")

endmodule

// ===== rtl/core/stg_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Sequencer and tone state. The envelope ratios go through the serial
// divider; the frame count of a start comes from a reciprocal multiply.
module stg_core #(
  parameter int PHASE_BITS = 32,
  parameter int FRAME_BITS = 23
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic [stg_pkg::INC_W-1:0]       in_inc,
  input  logic [stg_pkg::MS_W-1:0]        in_ms,
  input  logic [stg_pkg::RATE_W-1:0]      rate,
  input  logic [stg_pkg::RAMP_W-1:0]      attack,
  input  logic [stg_pkg::RAMP_W-1:0]      release_len,
  output logic                            res_valid,
  input  logic                            res_ready,
  output stg_pkg::result_t                res
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_SCALE = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_WAIT  = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  localparam logic [stg_pkg::DIVIDEND_W-1:0] FRAME_MAX =
    stg_pkg::DIVIDEND_W'((64'd1 << FRAME_BITS) - 64'd1);

  state_t state_r, state_nxt;

  logic                          func_r;
  logic [PHASE_BITS-1:0]         inc_r;
  logic [stg_pkg::MS_W-1:0]      ms_r;
  logic [PHASE_BITS-1:0]         phase_r;
  logic [PHASE_BITS-1:0]         step_r;
  logic [FRAME_BITS-1:0]         frame_r;
  logic [FRAME_BITS-1:0]         total_r;
  logic                          running_r;
  logic [stg_pkg::RAMP_W-1:0]    num_r;
  logic [stg_pkg::RAMP_W-1:0]    den_r;
  logic                          last_r;
  logic                          end_r;
  logic                          neg_r;
  logic [stg_pkg::SCALED_W-1:0]  scaled_r;
  logic [stg_pkg::DIVIDEND_W-1:0] count_r;
  stg_pkg::result_t              res_r;

  logic [stg_pkg::RAMP_W-1:0]    att_eff;
  logic [stg_pkg::RAMP_W-1:0]    rel_eff;
  logic [FRAME_BITS:0]           frame_p1;
  logic                          in_attack;
  logic                          in_release;
  logic [FRAME_BITS-1:0]         frames_left;
  logic [stg_pkg::DIVIDEND_W-1:0] frames_prod;
  logic [stg_pkg::SCALE_PROD_W-1:0] scale_prod;
  logic [stg_pkg::MAG_W+stg_pkg::RAMP_W-1:0] mag_prod;
  logic                          div_start;
  logic [stg_pkg::DIVIDEND_W-1:0] div_dividend;
  logic [stg_pkg::DIVISOR_W-1:0] div_divisor;
  logic [stg_pkg::DIVIDEND_W-1:0] div_quot;
  stg_pkg::div_stat_t            div_stat;
  logic [FRAME_BITS-1:0]         count_sat;
  logic [stg_pkg::MAG_W-1:0]     mag;

  // Ramp lengths of zero behave as one.
  assign att_eff = (attack == '0) ? stg_pkg::RAMP_W'(1) : attack;
  assign rel_eff = (release_len == '0) ? stg_pkg::RAMP_W'(1) : release_len;

  assign frame_p1    = {1'b0, frame_r} + (FRAME_BITS+1)'(1);
  assign in_attack   = frame_r < FRAME_BITS'(att_eff);
  assign in_release  = ({1'b0, frame_r} + (FRAME_BITS+1)'(rel_eff)) >= {1'b0, total_r};
  assign frames_left = total_r - frame_r;

  assign frames_prod = rate * ms_r;
  assign scale_prod  = scaled_r * stg_pkg::RECIP_125;
  assign mag_prod    = stg_pkg::FULL_MAG * num_r;

  assign div_start    = (state_r == S_MUL);
  assign div_dividend = stg_pkg::DIVIDEND_W'(mag_prod);
  assign div_divisor  = den_r;

  stg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // Long tones saturate to the largest frame count.
  assign count_sat = (count_r > FRAME_MAX) ? {FRAME_BITS{1'b1}} : count_r[FRAME_BITS-1:0];
  assign mag       = div_quot[stg_pkg::MAG_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PREP;
      end
      S_PREP: begin
        if (func_r == stg_pkg::FUNC_START) state_nxt = S_SCALE;
        else if (running_r)                state_nxt = S_MUL;
        else                               state_nxt = S_OUT;
      end
      S_SCALE: state_nxt = S_FIN;
      S_MUL:   state_nxt = S_WAIT;
      S_WAIT: begin
        if (div_stat.done) state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = (func_r == stg_pkg::FUNC_START) ? S_IDLE : S_OUT;
      end
      S_OUT: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      phase_r   <= '0;
      step_r    <= '0;
      frame_r   <= '0;
      total_r   <= '0;
      running_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r <= in_func;
            inc_r  <= in_inc[PHASE_BITS-1:0];
            ms_r   <= in_ms;
          end
        end
        S_PREP: begin
          if (func_r == stg_pkg::FUNC_TICK) begin
            // The sign comes from the phase before this tick's advance.
            neg_r   <= phase_r[PHASE_BITS-1];
            phase_r <= phase_r + step_r;
            res_r   <= '0;
            last_r  <= frame_p1 == {1'b0, total_r};
            end_r   <= frame_p1 >= {1'b0, total_r};
            if (in_attack) begin
              num_r <= frame_r[stg_pkg::RAMP_W-1:0];
              den_r <= att_eff;
            end else if (in_release) begin
              num_r <= frames_left[stg_pkg::RAMP_W-1:0];
              den_r <= rel_eff;
            end else begin
              // Full scale: dividing by one gives the constant itself.
              num_r <= stg_pkg::RAMP_W'(1);
              den_r <= stg_pkg::RAMP_W'(1);
            end
          end else begin
            // The low three bits drop out with the factor of eight in 1000.
            scaled_r <= frames_prod[stg_pkg::DIVIDEND_W-1:3];
          end
        end
        S_SCALE: begin
          count_r <= stg_pkg::DIVIDEND_W'(
            scale_prod[stg_pkg::SCALE_PROD_W-1:stg_pkg::RECIP_SHIFT]);
        end
        S_FIN: begin
          if (func_r == stg_pkg::FUNC_START) begin
            if ((count_r != '0) && (inc_r != '0)) begin
              step_r    <= inc_r;
              phase_r   <= '0;
              frame_r   <= '0;
              total_r   <= count_sat;
              running_r <= 1'b1;
            end
          end else begin
            res_r.sample <= neg_r ? (stg_pkg::SAMPLE_W'(0) - stg_pkg::SAMPLE_W'(mag))
                                  : stg_pkg::SAMPLE_W'(mag);
            res_r.active <= 1'b1;
            res_r.last   <= last_r;
            if (end_r) begin
              running_r <= 1'b0;
              frame_r   <= '0;
            end else begin
              frame_r <= frame_p1[FRAME_BITS-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res       = res_r;

  `STG_ASSERT_IMP(a_frame_in_tone, clk, rst_n, running_r, frame_r < total_r, "frame past end")
  `STG_ASSERT_IMP(a_res_no_div, clk, rst_n, res_valid, !div_stat.busy, "divider still busy")

endmodule

// ===== rtl/core/square_tone_envelope_generator_unit.sv =====
`timescale 1ns / 1ps
// A tick during a tone passes through prep, divider start, the wait on the
// 33-step serial divider and finish before its sample is presented; an idle
// tick goes straight from prep to its zero. Each tick, and a start, which
// produces no output, holds the input until done; output stalls add to it.
// Reset (synchronous, active low) stops any tone, clears phase and frame state,
// empties the output register and restores 48000 Hz, 240 and 960 frame ramps.
`include "assert_macros.svh"

module square_tone_envelope_generator_unit #(
  parameter int PHASE_BITS = 32,
  parameter int FRAME_BITS = 23
) (
  input  logic        clk,
  input  logic        rst_n,

  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] phase_increment, [47:32] duration_ms
  input  logic        in_tuser,   // [0] func: 0 start tone, 1 tick

  // Sample stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample (signed)
  output logic        out_tuser,  // [0] tone_active
  output logic        out_tlast,  // tone_last

  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers. The register index sits in address bits 3:2,
  // and writes to the unused fourth slot are dropped.
  logic [stg_pkg::RATE_W-1:0] rate_r;
  logic [stg_pkg::RAMP_W-1:0] attack_r;
  logic [stg_pkg::RAMP_W-1:0] release_r;
  logic                       cfg_wr;
  logic [stg_pkg::REG_IDX_W-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r    <= stg_pkg::RATE_RESET;
      attack_r  <= stg_pkg::ATTACK_RESET;
      release_r <= stg_pkg::RELEASE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        stg_pkg::REG_RATE:    rate_r    <= cfg_pwdata[stg_pkg::RATE_W-1:0];
        stg_pkg::REG_ATTACK:  attack_r  <= cfg_pwdata[stg_pkg::RAMP_W-1:0];
        stg_pkg::REG_RELEASE: release_r <= cfg_pwdata[stg_pkg::RAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      stg_pkg::REG_RATE:    cfg_prdata = 32'(rate_r);
      stg_pkg::REG_ATTACK:  cfg_prdata = 32'(attack_r);
      stg_pkg::REG_RELEASE: cfg_prdata = 32'(release_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // The core sequences one transaction at a time: a start scales rate times
  // milliseconds to a frame count with a reciprocal multiply, and a tick during
  // a tone works out the envelope ratio on the serial divider.
  logic             res_valid;
  logic             res_ready;
  stg_pkg::result_t res;

  stg_core #(
    .PHASE_BITS (PHASE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_func     (in_tuser),
    .in_inc      (in_tdata[31:0]),
    .in_ms       (in_tdata[47:32]),
    .rate        (rate_r),
    .attack      (attack_r),
    .release_len (release_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Output register. While a sample waits here the core already takes the
  // next input transaction; it only stalls once it has another sample ready.
  logic             out_valid_r;
  stg_pkg::result_t out_r;

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
        out_r       <= res;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.sample;
  assign out_tuser  = out_r.active;
  assign out_tlast  = out_r.last;

  // The last sample of a tone always belongs to a running tone.
  `STG_ASSERT_IMP(a_last_active, clk, rst_n, out_tvalid && out_tlast, out_tuser, "last not active")

endmodule

// ===== bench/tone_sample_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams and the register port of the tone generator. It keeps
// its own model of the tone state, predicts one sample per tick transaction
// and compares every sample transaction against the oldest prediction.
module tone_sample_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int unsigned pending,
  output int unsigned mismatches
);

  localparam longint unsigned FULL_SCALE = 22936;
  localparam longint unsigned FRAME_MAX  = (64'd1 << 23) - 1;
  // The block holds at most two samples at once; the ring has ample room.
  localparam int unsigned     DUE_DEPTH  = 8;

  typedef struct packed {
    logic signed [15:0] level;
    logic               active;
    logic               last;
  } tone_sample_t;

  logic [16:0] rate_hz;
  logic [11:0] attack_len;
  logic [11:0] release_len;

  logic [31:0] phase;
  logic [31:0] phase_step;
  logic [22:0] frame_pos;
  logic [22:0] frame_count;
  logic        tone_on;

  tone_sample_t samples_due [DUE_DEPTH];
  logic [2:0]   due_head;
  logic [2:0]   due_tail;
  int unsigned  due_count;

  // A start loads a new tone unless its frame count or its step is zero.
  function automatic void load_tone(logic [31:0] step, logic [15:0] ms);
    longint unsigned frames;
    frames = (longint'(rate_hz) * longint'(ms)) / 1000;
    if (frames > FRAME_MAX) frames = FRAME_MAX;
    if (frames != 0 && step != 0) begin
      phase_step  = step;
      phase       = '0;
      frame_pos   = '0;
      frame_count = frames[22:0];
      tone_on     = 1'b1;
    end
  endfunction

  function automatic tone_sample_t tick_sample();
    tone_sample_t    s;
    longint unsigned frame, total, att, rel, mag;
    logic [15:0]     mag16;
    s = '0;
    if (tone_on) begin
      frame = frame_pos;
      total = frame_count;
      att   = (attack_len == 0) ? 1 : attack_len;
      rel   = (release_len == 0) ? 1 : release_len;
      if (frame < att) mag = (FULL_SCALE * frame) / att;
      else if (frame + rel >= total) mag = (FULL_SCALE * (total - frame)) / rel;
      else mag = FULL_SCALE;
      mag16    = mag[15:0];
      s.level  = phase[31] ? (16'd0 - mag16) : mag16;
      s.active = 1'b1;
      s.last   = (frame + 1 == total);
      if (frame + 1 >= total) begin
        tone_on   = 1'b0;
        frame_pos = '0;
      end else begin
        frame_pos = frame_pos + 23'd1;
      end
    end
    // The phase keeps running even when no tone is playing.
    phase = phase + phase_step;
    return s;
  endfunction

  always @(posedge clk) begin
    tone_sample_t want;
    tone_sample_t fresh;
    if (!rst_n) begin
      rate_hz     = stg_pkg::RATE_RESET;
      attack_len  = stg_pkg::ATTACK_RESET;
      release_len = stg_pkg::RELEASE_RESET;
      phase       = '0;
      phase_step  = '0;
      frame_pos   = '0;
      frame_count = '0;
      tone_on     = 1'b0;
      due_head    = '0;
      due_tail    = '0;
      due_count   = 0;
      mismatches  = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_count == 0) begin
          $error("unexpected sample transaction: sample %0d", $signed(out_tdata));
          mismatches++;
        end else begin
          want      = samples_due[due_head];
          due_head  = due_head + 3'd1;
          due_count = due_count - 1;
          if (out_tdata !== want.level) begin
            $error("sample: expected %0d, actual %0d", want.level, $signed(out_tdata));
            mismatches++;
          end
          if (out_tuser !== want.active) begin
            $error("tone_active: expected %0b, actual %0b", want.active, out_tuser);
            mismatches++;
          end
          if (out_tlast !== want.last) begin
            $error("tone_last: expected %0b, actual %0b", want.last, out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == stg_pkg::FUNC_TICK) begin
          fresh = tick_sample();
          if (due_count == DUE_DEPTH) begin
            $error("prediction ring overflow: sample expected %0d, actual none",
                   fresh.level);
            mismatches++;
          end else begin
            samples_due[due_tail] = fresh;
            due_tail  = due_tail + 3'd1;
            due_count = due_count + 1;
          end
        end else begin
          load_tone(in_tdata[31:0], in_tdata[47:32]);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          stg_pkg::REG_RATE:    rate_hz = cfg_pwdata[16:0];
          stg_pkg::REG_ATTACK:  attack_len = cfg_pwdata[11:0];
          stg_pkg::REG_RELEASE: release_len = cfg_pwdata[11:0];
          default: ;
        endcase
      end
    end
    pending = due_count;
  end

endmodule

// ===== bench/tb_square_tone_envelope_generator_unit.sv =====
`timescale 1ns / 1ps

// Top of the tone generator bench. This module only makes stimulus: start and
// tick transactions on the input stream, register writes between phases, and
// random back-pressure on the sample stream. All prediction and comparison
// lives in the checker instantiated next to the block, which reports how many
// samples are still owed and how many mismatches it has seen.
module tb_square_tone_envelope_generator_unit;

  // A tone tick yields its sample after the serial divider finishes, and a start
  // ends with nothing to show for it.
  localparam int  SETTLE_CYCLES = 80;
  // Watchdog limit, several times the length of the slowest legal run.
  localparam real TIMEOUT_NS    = 3.0e6;
  localparam int  PHASE_ITEMS   = 65;
  localparam int  PHASES        = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // [31:0] phase_increment, [47:32] duration_ms
  logic        in_tuser = 1'b0; // [0] func

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] sample (signed)
  logic        out_tuser;       // [0] tone_active
  logic        out_tlast;

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int unsigned pending;
  int unsigned mismatches;

  // When calm is set neither side idles; the closing phase runs this way.
  logic        calm = 1'b0;
  int unsigned items_sent = 0;
  int unsigned ready_hold = 0;

  square_tone_envelope_generator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  tone_sample_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_pready (cfg_pready),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sample-side back-pressure: random stalls between ready runs of varying
  // length, some long enough to count as stretches with no idling.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold <= 0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 12);
    end else begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 40);
    end
  end

  // Every task below is entered just after a rising edge and returns just
  // after one. Handshake inputs are checked at the falling edge, where the
  // block's outputs are settled, so the following rising edge is the one
  // that completes the transaction.

  task automatic send_item(input logic func, input logic [31:0] step,
                           input logic [15:0] ms);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {ms, step};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    items_sent++;
  endtask

  // Ticks carry random bits in the fields that only a start uses, so those
  // bits toggle on every kind of transaction.
  task automatic send_tick();
    send_item(stg_pkg::FUNC_TICK, $urandom(), 16'($urandom()));
  endtask

  // Holds off the sender until every owed sample has arrived, then lets the
  // block finish any start it may still be digesting.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [stg_pkg::REG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(negedge clk); while (!cfg_pready);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [16:0] rate, input logic [11:0] att,
                            input logic [11:0] rel);
    write_reg(stg_pkg::REG_RATE, 32'(rate));
    write_reg(stg_pkg::REG_ATTACK, 32'(att));
    write_reg(stg_pkg::REG_RELEASE, 32'(rel));
  endtask

  // One start followed by a run of ticks. Most tones are a few milliseconds
  // long so that they pass through attack, sustain and release and end;
  // the rest are long, empty or cut short by the next start.
  task automatic play_tone();
    logic [31:0] step;
    logic [15:0] ms;
    step = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom();
    ms   = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4));
    send_item(stg_pkg::FUNC_START, step, ms);
    repeat ($urandom_range(0, 40)) send_tick();
  endtask

  initial begin
    int unsigned phase_end;
    logic [16:0] rate;
    logic [11:0] att, rel;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings (48 kHz, 240 and 960 frame ramps).
    // An idle tick, an empty start that changes nothing, then a short tone.
    send_tick();
    send_item(stg_pkg::FUNC_START, 32'd0, 16'd100);
    send_item(stg_pkg::FUNC_START, 32'hFFFF_FFFF, 16'd1);
    repeat (3) send_tick();
    // An empty start while a tone plays leaves that tone running.
    send_item(stg_pkg::FUNC_START, 32'h8000_0000, 16'd0);
    send_tick();
    // A valid start restarts phase and frame from zero.
    send_item(stg_pkg::FUNC_START, 32'h4000_0000, 16'hFFFF);
    repeat (2) send_tick();
    drain();

    // Lowest rate and both ramps written as zero, which behave as one frame.
    // A 1 ms tone is 8 frames: it ends on the eighth tick, and the ninth
    // is an idle tick with the phase still stepping.
    set_config(17'd8000, 12'd0, 12'd0);
    send_item(stg_pkg::FUNC_START, 32'h1234_5679, 16'd1);
    repeat (9) send_tick();
    drain();

    // Top of the rate register with the longest ramps: the frame count of a
    // 65535 ms tone no longer fits and saturates.
    set_config(17'h1FFFF, 12'hFFF, 12'hFFF);
    send_item(stg_pkg::FUNC_START, 32'h8000_0001, 16'hFFFF);
    repeat (2) send_tick();

    // Random phases, each under its own settings. Switching settings drains
    // the block first, which is also where the sender waits for all results.
    for (int k = 0; k < PHASES; k++) begin
      drain();
      case (k)
        0: begin rate = 17'd8000;  att = 12'd1;   rel = 12'd1;   end
        1: begin rate = 17'd96000; att = 12'hFFF; rel = 12'hFFF; end
        2: begin rate = 17'h1FFFF; att = 12'd0;   rel = 12'd0;   end
        default: begin
          rate = ($urandom_range(0, 5) == 0) ? 17'($urandom())
                                             : 17'($urandom_range(8000, 16000));
          att  = ($urandom_range(0, 4) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 12));
          rel  = ($urandom_range(0, 4) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 12));
        end
      endcase
      calm <= (k == PHASES - 1);
      set_config(rate, att, rel);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) play_tone();
    end

    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
